>>> sv/cncr_pkg.sv
package cncr_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned T_W     = FRAC_BITS + 1;
  localparam int unsigned SPAN_W  = VALUE_WIDTH + 1;
  localparam int unsigned LATENCY = FRAC_BITS + 11;

  localparam logic [T_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [T_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  typedef enum logic [2:0] {
    REG_IN_MIN  = 3'd0,
    REG_IN_MAX  = 3'd1,
    REG_OUT_MIN = 3'd2,
    REG_OUT_MAX = 3'd3,
    REG_CURVE   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CURVE_LINEAR      = 3'd0,
    CURVE_SMOOTH      = 3'd1,
    CURVE_SMOOTHER    = 3'd2,
    CURVE_EASE_IN     = 3'd3,
    CURVE_EASE_OUT    = 3'd4,
    CURVE_EASE_IN_OUT = 3'd5
  } curve_e;

  typedef struct packed {
    logic valid;
    logic zero;
  } tag_t;

endpackage

>>> sv/cncr_div.sv
module cncr_div import cncr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tag_t              tag_i,
  input  logic [SPAN_W-1:0] num_i,
  input  logic [SPAN_W-1:0] span_i,
  output tag_t              tag_o,
  output logic [T_W-1:0]    t_o
);

  tag_t                 tag_q [FRAC_BITS];
  logic [SPAN_W-1:0]    rem_q [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q [FRAC_BITS];
  logic                 sat_q [FRAC_BITS];

  for (genvar s = 0; s < FRAC_BITS; s++) begin : g_step
    tag_t                 tag_in;
    logic [SPAN_W-1:0]    rem_in;
    logic [FRAC_BITS-1:0] quo_in;
    logic                 sat_in;
    logic [SPAN_W:0]      shl;
    logic [SPAN_W:0]      diff;
    logic                 ge;

    if (s == 0) begin : g_first
      assign tag_in = tag_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign sat_in = (num_i >= span_i);
    end else begin : g_next
      assign tag_in = tag_q[s-1];
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign sat_in = sat_q[s-1];
    end

    assign shl  = {rem_in, 1'b0};
    assign ge   = (shl >= {1'b0, span_i});
    assign diff = shl - {1'b0, span_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? diff[SPAN_W-1:0] : shl[SPAN_W-1:0];
      quo_q[s] <= {quo_in[FRAC_BITS-2:0], ge};
      sat_q[s] <= sat_in;
    end
  end

  assign tag_o = tag_q[FRAC_BITS-1];
  assign t_o   = sat_q[FRAC_BITS-1] ? ONE : {1'b0, quo_q[FRAC_BITS-1]};

endmodule

>>> sv/cncr_curve.sv
module cncr_curve import cncr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tag_t           tag_i,
  input  logic [T_W-1:0] t_i,
  input  logic [2:0]     mode_i,
  output tag_t           tag_o,
  output logic [T_W-1:0] r_o
);

  localparam int unsigned P_W = 2 * T_W + 1;
  localparam int unsigned S_W = T_W + 5;

  tag_t tag_q [5];

  // stage 1: squares
  logic [T_W-1:0] u;
  logic [T_W:0]   m3;
  logic [P_W-1:0] tt, uu;
  logic [T_W-1:0] t1_q, t2_1_q, u2_1_q;
  logic [T_W:0]   m3_q;

  assign u  = ONE - t_i;
  assign m3 = (T_W + 1)'(ONE) * (T_W + 1)'(3) - {t_i, 1'b0};
  assign tt = P_W'(t_i) * P_W'(t_i);
  assign uu = P_W'(u) * P_W'(u);

  always_ff @(posedge clk_i) begin
    t1_q   <= t_i;
    t2_1_q <= tt[FRAC_BITS +: T_W];
    u2_1_q <= uu[FRAC_BITS +: T_W];
    m3_q   <= m3;
  end

  // stage 2: cube and smoothstep
  logic [P_W-1:0] p3, pss;
  logic [T_W-1:0] t2_q, t2_2_q, u2_2_q, t3_2_q;
  logic [T_W:0]   ss_2_q;

  assign p3  = P_W'(t2_1_q) * P_W'(t1_q);
  assign pss = P_W'(t2_1_q) * P_W'(m3_q);

  always_ff @(posedge clk_i) begin
    t2_q   <= t1_q;
    t2_2_q <= t2_1_q;
    u2_2_q <= u2_1_q;
    t3_2_q <= p3[FRAC_BITS +: T_W];
    ss_2_q <= pss[FRAC_BITS +: (T_W + 1)];
  end

  // stage 3: fourth power
  logic [P_W-1:0] p4;
  logic [T_W-1:0] t3_q, t2_3_q, u2_3_q, t3_3_q, t4_3_q;
  logic [T_W:0]   ss_3_q;

  assign p4 = P_W'(t3_2_q) * P_W'(t2_q);

  always_ff @(posedge clk_i) begin
    t3_q   <= t2_q;
    t2_3_q <= t2_2_q;
    u2_3_q <= u2_2_q;
    t3_3_q <= t3_2_q;
    t4_3_q <= p4[FRAC_BITS +: T_W];
    ss_3_q <= ss_2_q;
  end

  // stage 4: fifth power
  logic [P_W-1:0] p5;
  logic [T_W-1:0] t4_q, t2_4_q, u2_4_q, t3_4_q, t4_4_q, t5_4_q;
  logic [T_W:0]   ss_4_q;

  assign p5 = P_W'(t4_3_q) * P_W'(t3_q);

  always_ff @(posedge clk_i) begin
    t4_q   <= t3_q;
    t2_4_q <= t2_3_q;
    u2_4_q <= u2_3_q;
    t3_4_q <= t3_3_q;
    t4_4_q <= t4_3_q;
    t5_4_q <= p5[FRAC_BITS +: T_W];
    ss_4_q <= ss_3_q;
  end

  // stage 5: select and clamp
  logic [S_W-1:0]        pos, neg;
  logic signed [S_W-1:0] sm, rs;
  logic [T_W-1:0]        r_d, r_q;

  assign pos = S_W'(t5_4_q) * S_W'(6) + S_W'(t3_4_q) * S_W'(10);
  assign neg = S_W'(t4_4_q) * S_W'(15);
  assign sm  = $signed(pos - neg);

  always_comb begin
    case (mode_i)
      CURVE_SMOOTH:      rs = $signed(S_W'(ss_4_q));
      CURVE_SMOOTHER:    rs = sm;
      CURVE_EASE_IN:     rs = $signed(S_W'(t2_4_q));
      CURVE_EASE_OUT:    rs = $signed(S_W'(ONE)) - $signed(S_W'(u2_4_q));
      CURVE_EASE_IN_OUT: begin
        if (t4_q < HALF) begin
          rs = $signed(S_W'({t2_4_q, 1'b0}));
        end else begin
          rs = $signed(S_W'(ONE)) - $signed(S_W'({u2_4_q, 1'b0}));
        end
      end
      default:           rs = $signed(S_W'(t4_q));
    endcase
    if (rs < 0) begin
      r_d = '0;
    end else if (rs > $signed(S_W'(ONE))) begin
      r_d = ONE;
    end else begin
      r_d = rs[T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < 5; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign tag_o = tag_q[4];
  assign r_o   = r_q;

endmodule

>>> sv/clamp_normalize_curve_remap.sv
// the result strobe follows the start transfer through the registered stages
// (three front stages, one divider stage per fraction bit, five curve stages, three scale stages)
// throughput: one sample per clock, busy stays low
// the receiver cannot stall, so a result is shown for one cycle only
// reset clears all valid bits and loads the register reset values
module clamp_normalize_curve_remap import cncr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] sample_in_i,
  output logic                   result_valid_o,
  output logic [VALUE_WIDTH-1:0] mapped_out_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned HI_W  = SPAN_W - FRAC_BITS;
  localparam int unsigned PH_W  = T_W + HI_W;
  localparam int unsigned PL_W  = T_W + FRAC_BITS;
  localparam int unsigned SC_W  = PH_W + 1;
  localparam int unsigned RES_W = SC_W + 1;

  logic fire;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign fire        = start & ~busy;

  // configuration registers
  logic signed [VALUE_WIDTH-1:0] in_min_q, in_max_q, out_min_q, out_max_q;
  logic [2:0]                    curve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_min_q  <= '0;
      in_max_q  <= VALUE_WIDTH'(ONE);
      out_min_q <= '0;
      out_max_q <= VALUE_WIDTH'(ONE);
      curve_q   <= CURVE_LINEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_IN_MIN:  in_min_q  <= cfg_data_i;
        REG_IN_MAX:  in_max_q  <= cfg_data_i;
        REG_OUT_MIN: out_min_q <= cfg_data_i;
        REG_OUT_MAX: out_max_q <= cfg_data_i;
        REG_CURVE:   curve_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // ordered bounds and spans
  logic signed [VALUE_WIDTH-1:0] ilo_q, ihi_q, olo_q, ohi_q;
  logic [SPAN_W-1:0]             span_q, ospan_q;
  logic                          zero_q;

  always_ff @(posedge clk_i) begin
    ilo_q   <= (in_min_q > in_max_q) ? in_max_q : in_min_q;
    ihi_q   <= (in_min_q > in_max_q) ? in_min_q : in_max_q;
    olo_q   <= (out_min_q > out_max_q) ? out_max_q : out_min_q;
    ohi_q   <= (out_min_q > out_max_q) ? out_min_q : out_max_q;
    span_q  <= SPAN_W'(ihi_q) - SPAN_W'(ilo_q);
    ospan_q <= SPAN_W'(ohi_q) - SPAN_W'(olo_q);
    zero_q  <= (ihi_q == ilo_q);
  end

  // front stages: capture, clamp, offset
  tag_t                          tag_a_q, tag_b_q, tag_c_q;
  logic signed [VALUE_WIDTH-1:0] x_q, xc_q;
  logic [SPAN_W-1:0]             num_q;

  always_ff @(posedge clk_i) begin
    x_q <= sample_in_i;
    if (x_q < ilo_q) begin
      xc_q <= ilo_q;
    end else if (x_q > ihi_q) begin
      xc_q <= ihi_q;
    end else begin
      xc_q <= x_q;
    end
    num_q <= SPAN_W'(xc_q) - SPAN_W'(ilo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= '{valid: fire, zero: 1'b0};
      tag_b_q <= tag_a_q;
      tag_c_q <= '{valid: tag_b_q.valid, zero: zero_q};
    end
  end

  tag_t           tag_div, tag_crv;
  logic [T_W-1:0] t_div, r_crv;

  cncr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_c_q),
    .num_i  (num_q),
    .span_i (span_q),
    .tag_o  (tag_div),
    .t_o    (t_div)
  );

  cncr_curve u_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_div),
    .t_i    (t_div),
    .mode_i (curve_q),
    .tag_o  (tag_crv),
    .r_o    (r_crv)
  );

  // scale into output range
  tag_t                          tag_k1_q, tag_k2_q;
  logic [PH_W-1:0]               phi_q;
  logic [PL_W-1:0]               plo_q;
  logic [SC_W-1:0]               scaled_q;
  logic signed [RES_W-1:0]       res;
  logic signed [RES_W-1:0]       smax, smin;
  logic [VALUE_WIDTH-1:0]        mapped_d, mapped_q;
  logic                          valid_q;

  always_ff @(posedge clk_i) begin
    phi_q    <= PH_W'(r_crv) * PH_W'(ospan_q[SPAN_W-1:FRAC_BITS]);
    plo_q    <= PL_W'(r_crv) * PL_W'(ospan_q[FRAC_BITS-1:0]);
    scaled_q <= SC_W'(phi_q) + SC_W'(plo_q[PL_W-1:FRAC_BITS]);
  end

  assign smax = $signed(RES_W'({1'b0, {(VALUE_WIDTH - 1){1'b1}}}));
  assign smin = -smax - RES_W'(1);
  assign res  = $signed(RES_W'(olo_q)) + $signed(RES_W'(scaled_q));

  always_comb begin
    if (tag_k2_q.zero) begin
      mapped_d = olo_q;
    end else if (res > smax) begin
      mapped_d = smax[VALUE_WIDTH-1:0];
    end else if (res < smin) begin
      mapped_d = smin[VALUE_WIDTH-1:0];
    end else begin
      mapped_d = res[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mapped_q <= mapped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_k1_q <= '0;
      tag_k2_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      tag_k1_q <= tag_crv;
      tag_k2_q <= tag_k1_q;
      valid_q  <= tag_k2_q.valid;
    end
  end

  assign result_valid_o = valid_q;
  assign mapped_out_o   = mapped_q;

  // every strobe comes from a matching earlier start transfer
  a_strobe_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(fire && rst_ni, LATENCY))
    else $error("result strobe without matching start");

  // no transfer is lost on the way
  a_start_gives_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(fire && rst_ni, LATENCY) |-> result_valid_o)
    else $error("start transfer produced no result");

  // zero span items carry the output minimum
  a_zero_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_k2_q.valid && tag_k2_q.zero |=> mapped_out_o == $past(olo_q))
    else $error("zero span result differs from output minimum");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import cncr_pkg::*;

  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
  localparam longint LIMIT = 400000;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VALUE_WIDTH-1:0] sample_in_i = '0;
  logic result_valid_o;
  logic [VALUE_WIDTH-1:0] mapped_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [VALUE_WIDTH-1:0] cfg_data_i = '0;

  logic [31:0] in_lo_q = 32'd0, in_hi_q = 32'd65536;
  logic [31:0] out_lo_q = 32'd0, out_hi_q = 32'd65536;
  logic [2:0] curve_q = CURVE_LINEAR;

  logic [31:0] mapped_fifo[$];
  int errors = 0;
  longint cycles = 0;
  bit gaps_on = 1'b1;

  clamp_normalize_curve_remap dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
    return (a * b) >> FRAC_BITS;
  endfunction

  function automatic logic [31:0] remap(logic [31:0] s);
    longint lo, hi, olo, ohi, x, tmp, res, r;
    longint unsigned span, num, t, u, t2, u2, t3, t4, t5, ospan, scaled;
    lo = $signed(in_lo_q);
    hi = $signed(in_hi_q);
    olo = $signed(out_lo_q);
    ohi = $signed(out_hi_q);
    x = $signed(s);
    if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
    if (olo > ohi) begin tmp = olo; olo = ohi; ohi = tmp; end
    res = olo;
    if (hi != lo) begin
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      span = hi - lo;
      num = x - lo;
      t = (num >= span) ? UNIT : (num << FRAC_BITS) / span;
      u = UNIT - t;
      t2 = fmul(t, t);
      u2 = fmul(u, u);
      case (curve_q)
        CURVE_SMOOTH: r = fmul(t2, 3 * UNIT - 2 * t);
        CURVE_SMOOTHER: begin
          t3 = fmul(t2, t);
          t4 = fmul(t3, t);
          t5 = fmul(t4, t);
          r = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
        end
        CURVE_EASE_IN: r = t2;
        CURVE_EASE_OUT: r = longint'(UNIT) - longint'(u2);
        CURVE_EASE_IN_OUT: r = (t < UNIT / 2) ? 2 * longint'(t2)
                                              : longint'(UNIT) - 2 * longint'(u2);
        default: r = t;
      endcase
      if (r < 0) r = 0;
      if (r > longint'(UNIT)) r = UNIT;
      ospan = ohi - olo;
      scaled = r * (ospan >> FRAC_BITS) + ((r * (ospan & (UNIT - 1))) >> FRAC_BITS);
      res = olo + longint'(scaled);
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (mapped_fifo.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, mapped_out_o);
        errors++;
      end else begin
        if (mapped_out_o !== mapped_fifo[0]) begin
          $display("%0t mapped_out mismatch: expected %h actual %h", $time,
                   mapped_fifo[0], mapped_out_o);
          errors++;
        end
        void'(mapped_fifo.pop_front());
      end
    end
  end

  task automatic idle_burst();
    if (gaps_on && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_sample(logic [31:0] s);
    start <= 1'b1;
    sample_in_i <= s;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    mapped_fifo = {mapped_fifo, remap(s)};
    idle_burst();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (mapped_fifo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 3) @(posedge clk_i);
  endtask

  // leaves valid high, cfg_done lowers it
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_IN_MIN: in_lo_q = data;
      REG_IN_MAX: in_hi_q = data;
      REG_OUT_MIN: out_lo_q = data;
      REG_OUT_MAX: out_hi_q = data;
      REG_CURVE: curve_q = data[2:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_ranges(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] m);
    drain();
    write_reg(REG_IN_MIN, a);
    write_reg(REG_IN_MAX, b);
    write_reg(REG_OUT_MIN, c);
    write_reg(REG_OUT_MAX, d);
    write_reg(REG_CURVE, m);
    cfg_done();
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'd0;
      3: return 32'd65536;
      4: return 32'($signed($urandom_range(600000)) - 300000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    longint lo, hi, span;
    lo = $signed(in_lo_q);
    hi = $signed(in_hi_q);
    if (lo > hi) begin span = lo; lo = hi; hi = span; end
    span = hi - lo + 1;
    case ($urandom_range(9))
      0: return lo[31:0];
      1: return hi[31:0];
      2: return 32'(lo - 1);
      3: return 32'(hi + 1);
      4, 5: return $urandom;
      default: return 32'(lo + longint'({$urandom, $urandom} % span));
    endcase
  endfunction

  task automatic test_reset_values();
    send_sample(32'd0);
    send_sample(32'd32768);
    send_sample(32'd65536);
    send_sample(S_MIN);
    send_sample(S_MAX);
  endtask

  task automatic test_curve_shapes();
    for (int m = 0; m < 8; m++) begin
      set_ranges(32'd0, 32'd65536, 32'd0, 32'd65536, 32'(m));
      send_sample(32'd16384);
      send_sample(32'd32768);
    end
  endtask

  task automatic test_special_cases();
    // reversed bounds on both ranges
    set_ranges(32'd65536, 32'hffff_0000, 32'd200000, 32'hfff0_0000, CURVE_SMOOTH);
    send_sample(32'd0);
    send_sample(32'hffff_8000);
    // zero input span
    set_ranges(32'd5000, 32'd5000, 32'd777, 32'd99999, CURVE_EASE_OUT);
    send_sample(32'd5000);
    send_sample(S_MAX);
    // widest ranges
    set_ranges(S_MIN, S_MAX, S_MIN, S_MAX, CURVE_LINEAR);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(32'd0);
    // unused register indexes are ignored
    drain();
    for (int i = REG_CURVE + 1; i < 8; i++) write_reg(3'(i), 32'hffff_ffff);
    cfg_done();
    send_sample(32'h4000_0000);
  endtask

  task automatic test_random_stream();
    for (int p = 0; p < 20; p++) begin
      if (p == 18) gaps_on = 1'b0;
      set_ranges(pick_value(), pick_value(), pick_value(), pick_value(),
                 ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(7)));
      repeat (56) send_sample(pick_sample());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_curve_shapes();
    test_special_cases();
    test_random_stream();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/cncr_pkg.sv
sv/cncr_div.sv
sv/cncr_curve.sv
sv/clamp_normalize_curve_remap.sv
verif/tb.sv
